FILE: hdl/mbrd_pkg.sv
// Package: shared types, constants and helper functions of the bus region decoder.
package mbrd_pkg;

  // Field widths of the bus word.
  localparam int unsigned CmdW  = 2;
  localparam int unsigned SizeW = 2;
  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned WaitW = 4;

  // The unified store is 32 bits wide, four byte lanes selected by the two low address bits.
  localparam int unsigned FlatW = 26;
  localparam int unsigned RowW  = 24;
  localparam int unsigned NumRows = 32'h0081_D300;

  // Store sizes in bytes.
  localparam int unsigned RomBytes   = 32'h0200_0000;
  localparam int unsigned EwramBytes = 32'h0004_0000;
  localparam int unsigned VramBytes  = 32'h0001_8000;

  // Row address width of cart ROM, which the clearing pass sweeps.
  localparam int unsigned RomRowW = 23;

  // Byte offsets of each store inside the unified store.
  localparam logic [FlatW-1:0] BaseRom   = 26'h000_0000;
  localparam logic [FlatW-1:0] BaseEwram = 26'h200_0000;
  localparam logic [FlatW-1:0] BaseVram  = 26'h204_0000;
  localparam logic [FlatW-1:0] BaseIwram = 26'h205_8000;
  localparam logic [FlatW-1:0] BaseSram  = 26'h206_0000;
  localparam logic [FlatW-1:0] BaseBios  = 26'h207_0000;
  localparam logic [FlatW-1:0] BaseIo    = 26'h207_4000;
  localparam logic [FlatW-1:0] BasePal   = 26'h207_4400;
  localparam logic [FlatW-1:0] BaseOam   = 26'h207_4800;

  // Interrupt flag register address and the reset contents of the I/O store.
  localparam logic [AddrW-1:0] IfAddr    = 32'h0400_0202;
  localparam logic [7:0]       IoRstRow  = 8'h4C;
  localparam logic [DataW-1:0] IoRstData = 32'h0000_03FF;

  typedef enum logic [CmdW-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_DIRECT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [SizeW-1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_RSVD = 2'd3
  } size_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_EX    = 5'b01000,
    ST_NXT   = 5'b10000
  } state_e;

  // Location of one access in the unified store.
  typedef struct packed {
    logic            hit;
    logic            io;
    logic [7:0]      io_row;
    logic [RowW-1:0] row;
    logic [1:0]      lane;
  } map_t;

  // Wait states by region nibble and access width.
  function automatic logic [WaitW-1:0] wait_states(input logic [3:0] region,
                                                   input logic is_word);
    logic [WaitW-1:0] w;
    unique case (region)
      4'h2:                             w = is_word ? 4'd6 : 4'd3;
      4'h5, 4'h6:                       w = is_word ? 4'd2 : 4'd1;
      4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD: w = is_word ? 4'd8 : 4'd5;
      4'hE:                             w = 4'd5;
      default:                          w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/mbrd_in_if.sv
// Interface: bus access channel with valid/ready handshake.
interface mbrd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mbrd_pkg::CmdW-1:0]   cmd;
  logic [mbrd_pkg::SizeW-1:0]  access_size;
  logic [mbrd_pkg::AddrW-1:0]  address;
  logic [mbrd_pkg::DataW-1:0]  write_data;

  modport source (output valid, cmd, access_size, address, write_data, input ready);
  modport sink   (input valid, cmd, access_size, address, write_data, output ready);
endinterface

FILE: hdl/mbrd_out_if.sv
// Interface: result channel with valid/ready handshake.
interface mbrd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbrd_pkg::DataW-1:0]  read_data;
  logic [mbrd_pkg::WaitW-1:0]  wait_cycles;

  modport source (output valid, read_data, wait_cycles, input ready);
  modport sink   (input valid, read_data, wait_cycles, output ready);
endinterface

FILE: hdl/mbrd_ram.sv
// Generic simple dual-port RAM with registered read data.
module mbrd_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hdl/mbrd_map.sv
// Address map: decodes a masked byte address to a row and lane of the unified store.
module mbrd_map (
  input  logic [27:0]          addr_i,
  output mbrd_pkg::map_t       map_o
);

  logic [11:0]                 blk;
  logic [16:0]                 vram_off;
  logic [16:0]                 vram_idx;
  logic [mbrd_pkg::FlatW-1:0]  flat;
  logic                        hit;
  logic                        io;

  assign blk      = addr_i[27:16];
  assign vram_off = addr_i[16:0];

  // Video offsets past the store wrap back by one store size.
  assign vram_idx = (vram_off >= 17'(mbrd_pkg::VramBytes))
                  ? vram_off - 17'(mbrd_pkg::VramBytes) : vram_off;

  // Region decode on the 64 KB block number.
  always_comb begin
    hit  = 1'b1;
    io   = 1'b0;
    flat = '0;
    priority if (blk == 12'h000) begin
      flat = mbrd_pkg::BaseBios + 26'(addr_i[13:0]);
    end else if (addr_i[27:18] == 10'h080) begin
      flat = mbrd_pkg::BaseEwram + 26'(addr_i[17:0]);
    end else if (blk == 12'h300) begin
      flat = mbrd_pkg::BaseIwram + 26'(addr_i[14:0]);
    end else if (blk == 12'h400) begin
      io   = 1'b1;
      flat = mbrd_pkg::BaseIo + 26'(addr_i[9:0]);
    end else if (blk == 12'h500) begin
      flat = mbrd_pkg::BasePal + 26'(addr_i[9:0]);
    end else if (blk == 12'h600 || blk == 12'h601) begin
      flat = mbrd_pkg::BaseVram + 26'(vram_idx);
    end else if (blk == 12'h700) begin
      flat = mbrd_pkg::BaseOam + 26'(addr_i[9:0]);
    end else if (addr_i[27:25] == 3'b100) begin
      flat = mbrd_pkg::BaseRom + 26'(addr_i[24:0]);
    end else if (blk == 12'hE00) begin
      flat = mbrd_pkg::BaseSram + 26'(addr_i[15:0]);
    end else begin
      hit = 1'b0;
    end
  end

  assign map_o.hit    = hit;
  assign map_o.io     = io;
  assign map_o.io_row = addr_i[9:2];
  assign map_o.row    = flat[mbrd_pkg::FlatW-1:2];
  assign map_o.lane   = flat[1:0];

endmodule

FILE: hdl/memory_bus_region_decoder.sv
// Top level: memory bus region decoder over one unified store with read-modify-write.
// Sequence: an accepted access word is read from the store, registered in the read step
// and merged in execute, which registers the result word; a direct write passes read and
// execute once per byte, its two bytes going through the single store one after the other.
// A stalled result word holds the next access in execute; no new access word is accepted
// until the last is done. Reset: asynchronous, active low. After reset a clearing pass
// zeroes cart ROM, one row a cycle, during which no access word is accepted.
module memory_bus_region_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbrd_in_if.sink           in_i,
  mbrd_out_if.source        out_o
);

  mbrd_pkg::state_e                 state_q, state_d;
  mbrd_pkg::cmd_e                   cmd_q;
  mbrd_pkg::size_e                  size_q;
  logic [mbrd_pkg::AddrW-1:0]       addr_q;
  logic [mbrd_pkg::DataW-1:0]       data_q;
  mbrd_pkg::map_t                   map_q, map_res;
  logic [mbrd_pkg::DataW-1:0]       row_q;
  logic                             byte1_q;
  logic [mbrd_pkg::RomRowW-1:0]     clr_q;
  logic [255:0]                     io_valid_q;
  logic                             out_valid_q;
  logic [mbrd_pkg::DataW-1:0]       rd_data_q;
  logic [mbrd_pkg::WaitW-1:0]       wait_q;

  logic                             in_acc;
  logic [1:0]                       al_mask;
  logic [27:0]                      map_addr;
  logic                             re;
  logic                             we;
  logic [mbrd_pkg::RowW-1:0]        waddr;
  logic [mbrd_pkg::DataW-1:0]       wdata;
  logic [mbrd_pkg::DataW-1:0]       rdata;

  logic [1:0]                       sz_mask;
  logic [1:0]                       rot;
  logic [mbrd_pkg::DataW-1:0]       gath;
  logic [63:0]                      rd_rot;
  logic [63:0]                      wr_rot;
  logic [mbrd_pkg::DataW-1:0]       rd_val;
  logic [mbrd_pkg::DataW-1:0]       wr_val;
  logic [3:0]                       be;
  logic [mbrd_pkg::DataW-1:0]       wr_sh;
  logic [mbrd_pkg::DataW-1:0]       new_row;
  logic                             is_word;
  logic                             out_free;
  logic                             ex_done;
  logic                             ex_wr;
  logic [mbrd_pkg::DataW-1:0]       res_data;
  logic [mbrd_pkg::WaitW-1:0]       res_wait;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == mbrd_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  // Alignment mask of the incoming access.
  always_comb begin
    unique case (mbrd_pkg::size_e'(in_i.access_size))
      mbrd_pkg::SZ_BYTE: al_mask = 2'b00;
      mbrd_pkg::SZ_HALF: al_mask = 2'b01;
      default:           al_mask = 2'b11;
    endcase
  end

  // Address into the map: the new word, or the second byte of a direct write.
  always_comb begin
    if (state_q == mbrd_pkg::ST_NXT) begin
      map_addr = {addr_q[27:16], addr_q[15:0] + 16'd1};
    end else if (mbrd_pkg::cmd_e'(in_i.cmd) == mbrd_pkg::CMD_DIRECT) begin
      map_addr = in_i.address[27:0];
    end else begin
      map_addr = in_i.address[27:0] & ~{26'd0, al_mask};
    end
  end

  mbrd_map u_map (
    .addr_i (map_addr),
    .map_o  (map_res)
  );

  // Store access: clearing pass, or the write-back of an access.
  assign re = in_acc || (state_q == mbrd_pkg::ST_NXT);
  always_comb begin
    if (state_q == mbrd_pkg::ST_CLEAR) begin
      we    = 1'b1;
      waddr = {1'b0, clr_q};
      wdata = '0;
    end else begin
      we    = ex_wr;
      waddr = map_q.row;
      wdata = new_row;
    end
  end

  mbrd_ram #(
    .Depth (mbrd_pkg::NumRows),
    .Width (mbrd_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (map_res.row),
    .rdata_o (rdata)
  );

  // Effective size: a direct write moves one byte per pass.
  always_comb begin
    if (cmd_q == mbrd_pkg::CMD_DIRECT) begin
      sz_mask = 2'b00;
    end else begin
      unique case (size_q)
        mbrd_pkg::SZ_BYTE: sz_mask = 2'b00;
        mbrd_pkg::SZ_HALF: sz_mask = 2'b01;
        default:           sz_mask = 2'b11;
      endcase
    end
  end

  assign rot     = addr_q[1:0] & sz_mask;
  assign is_word = (size_q == mbrd_pkg::SZ_WORD) || (size_q == mbrd_pkg::SZ_RSVD);
  assign gath    = row_q >> {map_q.lane, 3'b000};
  assign rd_rot  = {gath, gath} >> {rot, 3'b000};

  // Read value rotated right within the access width.
  always_comb begin
    unique case (sz_mask)
      2'b00:   rd_val = {24'd0, gath[7:0]};
      2'b01:   rd_val = rot[0] ? {16'd0, gath[7:0], gath[15:8]} : {16'd0, gath[15:0]};
      default: rd_val = rd_rot[31:0];
    endcase
  end

  // Write value rotated left, with the interrupt flag clear rule.
  always_comb begin
    wr_rot = {data_q, data_q} << {rot, 3'b000};
    unique case (sz_mask)
      2'b00: begin
        be     = 4'b0001;
        wr_val = {24'd0, (cmd_q == mbrd_pkg::CMD_DIRECT && byte1_q) ? data_q[15:8]
                                                                   : data_q[7:0]};
      end
      2'b01: begin
        be     = 4'b0011;
        wr_val = rot[0] ? {16'd0, data_q[7:0], data_q[15:8]} : {16'd0, data_q[15:0]};
        if (cmd_q == mbrd_pkg::CMD_WRITE && addr_q == mbrd_pkg::IfAddr) begin
          wr_val = {16'd0, gath[15:0] & ~wr_val[15:0]};
        end
      end
      default: begin
        be     = 4'b1111;
        wr_val = wr_rot[63:32];
      end
    endcase
  end

  // Merge the written bytes into the row.
  always_comb begin
    logic [3:0] be_sh;
    be_sh = be << map_q.lane;
    wr_sh = wr_val << {map_q.lane, 3'b000};
    for (int j = 0; j < 4; j++) begin
      new_row[8*j +: 8] = be_sh[j] ? wr_sh[8*j +: 8] : row_q[8*j +: 8];
    end
  end

  // Completion of the execute step and the result word.
  always_comb begin
    ex_done = 1'b0;
    ex_wr   = 1'b0;
    if (state_q == mbrd_pkg::ST_EX) begin
      if (cmd_q == mbrd_pkg::CMD_DIRECT && !byte1_q) begin
        ex_done = 1'b0;
        ex_wr   = map_q.hit;
      end else if (out_free) begin
        ex_done = 1'b1;
        ex_wr   = map_q.hit &&
                  (cmd_q == mbrd_pkg::CMD_WRITE || cmd_q == mbrd_pkg::CMD_DIRECT);
      end
    end
  end

  always_comb begin
    unique case (cmd_q)
      mbrd_pkg::CMD_READ: begin
        res_wait = mbrd_pkg::wait_states(addr_q[27:24], is_word);
        if (map_q.hit) begin
          res_data = rd_val;
        end else begin
          unique case (sz_mask)
            2'b00:   res_data = 32'h0000_00FF;
            2'b01:   res_data = 32'h0000_FFFF;
            default: res_data = 32'hFFFF_FFFF;
          endcase
        end
      end
      mbrd_pkg::CMD_WRITE: begin
        res_wait = mbrd_pkg::wait_states(addr_q[27:24], is_word);
        res_data = '0;
      end
      default: begin
        res_wait = '0;
        res_data = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbrd_pkg::ST_CLEAR: if (&clr_q) state_d = mbrd_pkg::ST_IDLE;
      mbrd_pkg::ST_IDLE:  if (in_acc) state_d = mbrd_pkg::ST_RD;
      mbrd_pkg::ST_RD:    state_d = mbrd_pkg::ST_EX;
      mbrd_pkg::ST_EX: begin
        if (cmd_q == mbrd_pkg::CMD_DIRECT && !byte1_q) begin
          state_d = mbrd_pkg::ST_NXT;
        end else if (ex_done) begin
          state_d = mbrd_pkg::ST_IDLE;
        end
      end
      mbrd_pkg::ST_NXT:   state_d = mbrd_pkg::ST_RD;
      default:            state_d = mbrd_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbrd_pkg::ST_CLEAR;
      clr_q       <= '0;
      byte1_q     <= 1'b0;
      io_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mbrd_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == mbrd_pkg::ST_EX && state_d == mbrd_pkg::ST_NXT) begin
        byte1_q <= 1'b1;
      end else if (ex_done) begin
        byte1_q <= 1'b0;
      end
      if (ex_wr && map_q.io) begin
        io_valid_q[map_q.io_row] <= 1'b1;
      end
      if (ex_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= mbrd_pkg::cmd_e'(in_i.cmd);
      size_q <= mbrd_pkg::size_e'(in_i.access_size);
      addr_q <= in_i.address;
      data_q <= in_i.write_data;
    end
    if (re) begin
      map_q <= map_res;
    end
    // An I/O row never written reads as its reset contents.
    if (state_q == mbrd_pkg::ST_RD) begin
      if (map_q.io && !io_valid_q[map_q.io_row]) begin
        row_q <= (map_q.io_row == mbrd_pkg::IoRstRow) ? mbrd_pkg::IoRstData : '0;
      end else begin
        row_q <= rdata;
      end
    end
    if (ex_done) begin
      rd_data_q <= res_data;
      wait_q    <= res_wait;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = rd_data_q;
  assign out_o.wait_cycles = wait_q;

endmodule

FILE: hdl/mbrd_checker.sv
// Checker: port-level properties of the bus region decoder, bound to the top level.
module mbrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic [3:0]  wait_cycles
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(wait_cycles))
    else $error("result word changed while stalled");

  // Only one access is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("access accepted while another is in flight");

  // Non-zero data only comes from a read, which always reports wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && read_data != 32'd0 |-> wait_cycles != 4'd0)
    else $error("read data without wait states");

  // Wait states never exceed the slowest region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> wait_cycles <= 4'd8)
    else $error("wait states out of range");

endmodule

bind memory_bus_region_decoder mbrd_checker u_mbrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .read_data   (out_o.read_data),
  .wait_cycles (out_o.wait_cycles)
);
